// File: hw/rtl/csnhs_pkg.sv
// ----------------------------------------------------------------------------
// csnhs_pkg
// Types, codes and constants shared by the circle segment next-hit search.
// ----------------------------------------------------------------------------
package csnhs_pkg;

    localparam logic [32:0] FULL_TURN = 33'h1_0000_0000;

    typedef struct packed {
        logic signed [31:0] begin_x;
        logic signed [31:0] begin_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic               last_segment;
    } seg_in_t;

    typedef struct packed {
        logic        hit_found;
        logic [32:0] turn_to_hit;
        logic [9:0]  hit_index;
    } hit_out_t;

    typedef enum logic [1:0] {
        REG_ORIGIN_X      = 2'd0,
        REG_ORIGIN_Y      = 2'd1,
        REG_RADIUS        = 2'd2,
        REG_CURRENT_ANGLE = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCALE,
        OP_MUL,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CAND,
        OP_NORM_LOAD,
        OP_NORM_STEP,
        OP_CORDIC_LOAD,
        OP_CORDIC_STEP,
        OP_TURN,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        SRC_PX,
        SRC_PY,
        SRC_DX,
        SRC_DY,
        SRC_R,
        SRC_A,
        SRC_H,
        SRC_C,
        SRC_N
    } mul_src_t;

    typedef enum logic [1:0] {
        MAC_SET,
        MAC_ADD,
        MAC_SUB
    } mac_mode_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_A,
        DST_H,
        DST_C,
        DST_DISC,
        DST_VX,
        DST_VY
    } mac_dst_t;

    typedef struct packed {
        mul_src_t  src_a;
        mul_src_t  src_b;
        mac_mode_t mode;
        mac_dst_t  dst;
    } mul_cmd_t;

    typedef struct packed {
        dp_op_t     op;
        mul_cmd_t   mul;
        logic       cand;
        logic [4:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        logic search_en;
        logic a_zero;
        logic disc_neg;
        logic n_ok;
        logic norm_small;
        logic mul_idle;
        logic last_item;
        logic out_free;
    } dp_status_t;

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/csnhs_datapath.sv
// ----------------------------------------------------------------------------
// csnhs_datapath
// Registers, multiply-accumulate, square root, normalise and CORDIC units,
// scan bookkeeping and the output register.
// ----------------------------------------------------------------------------
module csnhs_datapath #(
    parameter int MAX_SEGMENTS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  csnhs_pkg::seg_in_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output csnhs_pkg::hit_out_t   out_data,
    input  csnhs_pkg::dp_cmd_t    cmd,
    output csnhs_pkg::dp_status_t status
);
    import csnhs_pkg::*;

    localparam int PW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_SEGMENTS);

    // configuration
    logic signed [31:0] ox_reg, oy_reg;
    logic [30:0]        rad_reg;
    logic [31:0]        cur_reg;

    // segment geometry
    logic signed [33:0] px_reg, py_reg, dx_reg, dy_reg, r_reg;
    logic signed [33:0] px_next, py_next, dx_next, dy_next, r_next;
    logic               last_reg, last_next;
    logic signed [63:0] a_reg, h_reg, c_reg, n_reg;
    logic signed [63:0] a_next, h_next, c_next, n_next;
    logic [127:0]       disc_reg, disc_next, vx_reg, vx_next, vy_reg, vy_next;
    logic [66:0]        rem_reg, rem_next;
    logic [63:0]        root_reg, root_next;
    logic               nx_reg, nx_next, ny_reg, ny_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [31:0]        z_reg, z_next;
    logic               cskip_reg, cskip_next;
    logic [32:0]        seg_best_reg, seg_best_next;

    // multiply-accumulate
    logic [63:0]        mag_a_reg, mag_a_next, mag_b_reg, mag_b_next;
    logic               neg_reg, neg_next;
    mac_mode_t          mode_reg, mode_next;
    mac_dst_t           dst_reg, dst_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [63:0]        pp_reg, pp_next;
    logic [1:0]         pp_sh_reg, pp_sh_next;
    logic [127:0]       prod_reg, prod_next, acc_reg, acc_next;

    // scan state
    logic               engaged_reg, engaged_next;
    logic               best_valid_reg, best_valid_next;
    logic [32:0]        best_turn_reg, best_turn_next;
    logic [9:0]         best_index_reg, best_index_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    hit_out_t           out_data_reg, out_data_next;

    // combinational helpers
    logic signed [63:0] opa, opb;
    logic [33:0]        m_px, m_py, m_dx, m_dy, m_r, mx;
    logic [2:0]         k;
    logic [127:0]       pp_wide, acc_base;
    logic [66:0]        rem_sh, trial;
    logic signed [65:0] n_wide;
    logic signed [33:0] xs, ys, cx0, cy0;
    logic [31:0]        t_diff;
    logic [32:0]        turn;
    logic               upd;
    logic [PW+9:0]      pos_ext;
    logic               transfer;

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    function automatic logic signed [33:0] shrink(input logic signed [33:0] v,
                                                  input logic [2:0] s);
        logic [33:0] m;
        m = mag34(v) >> s;
        return v[33] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] pick(input mul_src_t s,
        input logic signed [33:0] px, input logic signed [33:0] py,
        input logic signed [33:0] dx, input logic signed [33:0] dy,
        input logic signed [33:0] r, input logic signed [63:0] a,
        input logic signed [63:0] h, input logic signed [63:0] c,
        input logic signed [63:0] n);
        logic signed [63:0] v;
        case (s)
            SRC_PX:  v = 64'(px);
            SRC_PY:  v = 64'(py);
            SRC_DX:  v = 64'(dx);
            SRC_DY:  v = 64'(dy);
            SRC_R:   v = 64'(r);
            SRC_A:   v = a;
            SRC_H:   v = h;
            SRC_C:   v = c;
            SRC_N:   v = n;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign transfer = out_valid_reg && !out_stall;

    always_comb
    begin
        px_next = px_reg; py_next = py_reg; dx_next = dx_reg; dy_next = dy_reg;
        r_next = r_reg; last_next = last_reg;
        a_next = a_reg; h_next = h_reg; c_next = c_reg; n_next = n_reg;
        disc_next = disc_reg; vx_next = vx_reg; vy_next = vy_reg;
        rem_next = rem_reg; root_next = root_reg;
        nx_next = nx_reg; ny_next = ny_reg;
        cx_next = cx_reg; cy_next = cy_reg; z_next = z_reg; cskip_next = cskip_reg;
        seg_best_next = seg_best_reg;
        mag_a_next = mag_a_reg; mag_b_next = mag_b_reg; neg_next = neg_reg;
        mode_next = mode_reg; dst_next = dst_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; pp_next = pp_reg; pp_sh_next = pp_sh_reg;
        prod_next = prod_reg; acc_next = acc_reg;
        engaged_next = engaged_reg; best_valid_next = best_valid_reg;
        best_turn_next = best_turn_reg; best_index_next = best_index_reg;
        pos_next = pos_reg;
        out_valid_next = transfer ? 1'b0 : out_valid_reg;
        out_data_next = out_data_reg;

        opa = pick(cmd.mul.src_a, px_reg, py_reg, dx_reg, dy_reg, r_reg,
                   a_reg, h_reg, c_reg, n_reg);
        opb = pick(cmd.mul.src_b, px_reg, py_reg, dx_reg, dy_reg, r_reg,
                   a_reg, h_reg, c_reg, n_reg);

        m_px = mag34(px_reg); m_py = mag34(py_reg); m_dx = mag34(dx_reg);
        m_dy = mag34(dy_reg); m_r = mag34(r_reg);
        mx = m_px;
        if (m_py > mx) mx = m_py;
        if (m_dx > mx) mx = m_dx;
        if (m_dy > mx) mx = m_dy;
        if (m_r > mx)  mx = m_r;
        if (mx[33:30] == 4'd0)      k = 3'd0;
        else if (mx[33:31] == 3'd0) k = 3'd1;
        else if (mx[33:32] == 2'd0) k = 3'd2;
        else if (!mx[33])           k = 3'd3;
        else                        k = 3'd4;

        case (pp_sh_reg)
            2'd0:    pp_wide = {64'd0, pp_reg};
            2'd1:    pp_wide = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_wide = {pp_reg, 64'd0};
            default: pp_wide = '0;
        endcase
        acc_base = (mode_reg == MAC_SET) ? 128'd0 : acc_reg;

        rem_sh = {rem_reg[64:0], disc_reg[127:126]};
        trial  = {1'b0, root_reg, 2'b01};

        n_wide = cmd.cand ? (-66'(h_reg) - $signed({2'b00, root_reg}))
                          : (-66'(h_reg) + $signed({2'b00, root_reg}));

        cx0 = nx_reg ? -$signed({4'd0, vx_reg[29:0]}) : $signed({4'd0, vx_reg[29:0]});
        cy0 = ny_reg ? -$signed({4'd0, vy_reg[29:0]}) : $signed({4'd0, vy_reg[29:0]});
        xs = cx_reg >>> cmd.iter;
        ys = cy_reg >>> cmd.iter;

        t_diff = z_reg - cur_reg;
        turn = (t_diff == 32'd0) ? FULL_TURN : {1'b0, t_diff};

        upd = (seg_best_reg != 33'd0) &&
              (!best_valid_reg || seg_best_reg < best_turn_reg);
        pos_ext = {10'd0, pos_reg};

        // multiply-accumulate runs on its own once started
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg < 3'd4)
            begin
                pp_next = (cnt_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0]) *
                          (cnt_reg[0] ? mag_b_reg[63:32] : mag_b_reg[31:0]);
                pp_sh_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
                prod_next = prod_reg + pp_wide;
            if (cnt_reg == 3'd5)
            begin
                acc_next = acc_base + (neg_reg ? ~prod_reg : prod_reg) +
                           {127'd0, neg_reg};
                busy_next = 1'b0;
                case (dst_reg)
                    DST_A:    a_next = acc_next[63:0];
                    DST_H:    h_next = acc_next[63:0];
                    DST_C:    c_next = acc_next[63:0];
                    DST_DISC: disc_next = acc_next;
                    DST_VX:   vx_next = acc_next;
                    DST_VY:   vy_next = acc_next;
                    default:  ;
                endcase
            end
        end

        case (cmd.op)
            OP_LOAD:
            begin
                px_next = 34'(in_data.begin_x) - 34'(ox_reg);
                py_next = 34'(in_data.begin_y) - 34'(oy_reg);
                dx_next = 34'(in_data.end_x) - 34'(in_data.begin_x);
                dy_next = 34'(in_data.end_y) - 34'(in_data.begin_y);
                r_next = $signed({3'd0, rad_reg});
                last_next = in_data.last_segment;
                seg_best_next = '0;
            end
            OP_SCALE:
            begin
                px_next = shrink(px_reg, k);
                py_next = shrink(py_reg, k);
                dx_next = shrink(dx_reg, k);
                dy_next = shrink(dy_reg, k);
                r_next = shrink(r_reg, k);
            end
            OP_MUL:
            begin
                mag_a_next = opa[63] ? 64'(-opa) : 64'(opa);
                mag_b_next = opb[63] ? 64'(-opb) : 64'(opb);
                neg_next = opa[63] ^ opb[63] ^ (cmd.mul.mode == MAC_SUB);
                mode_next = cmd.mul.mode;
                dst_next = cmd.mul.dst;
                prod_next = '0;
                cnt_next = '0;
                busy_next = 1'b1;
            end
            OP_SQRT_INIT:
            begin
                rem_next = '0;
                root_next = '0;
            end
            OP_SQRT_STEP:
            begin
                // one root bit per step, radicand consumed two bits at a time
                disc_next = {disc_reg[125:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next = rem_sh - trial;
                    root_next = {root_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    root_next = {root_reg[62:0], 1'b0};
                end
            end
            OP_CAND:
                n_next = n_wide[63:0];
            OP_NORM_LOAD:
            begin
                nx_next = vx_reg[127];
                ny_next = vy_reg[127];
                vx_next = vx_reg[127] ? -vx_reg : vx_reg;
                vy_next = vy_reg[127] ? -vy_reg : vy_reg;
            end
            OP_NORM_STEP:
            begin
                vx_next = vx_reg >> 1;
                vy_next = vy_reg >> 1;
            end
            OP_CORDIC_LOAD:
            begin
                cskip_next = (cy0 == 34'sd0);
                if (cy0 == 34'sd0)
                begin
                    cx_next = cx0;
                    cy_next = cy0;
                    z_next = cx0[33] ? 32'h8000_0000 : 32'd0;
                end
                else if (cx0[33])
                begin
                    cx_next = -cx0;
                    cy_next = -cy0;
                    z_next = 32'h8000_0000;
                end
                else
                begin
                    cx_next = cx0;
                    cy_next = cy0;
                    z_next = 32'd0;
                end
            end
            OP_CORDIC_STEP:
            begin
                if (!cskip_reg)
                begin
                    if (cy_reg > 34'sd0)
                    begin
                        cx_next = cx_reg + ys;
                        cy_next = cy_reg - xs;
                        z_next = z_reg + atan_entry(cmd.iter);
                    end
                    else
                    begin
                        cx_next = cx_reg - ys;
                        cy_next = cy_reg + xs;
                        z_next = z_reg - atan_entry(cmd.iter);
                    end
                end
            end
            OP_TURN:
            begin
                if (seg_best_reg == 33'd0 || turn < seg_best_reg)
                    seg_best_next = turn;
            end
            OP_FINISH:
            begin
                if (upd)
                begin
                    best_turn_next = seg_best_reg;
                    best_index_next = pos_ext[9:0];
                    best_valid_next = 1'b1;
                end
                if (pos_reg < POS_MAX)
                    pos_next = pos_reg + PW'(1);
                if (last_reg)
                begin
                    out_valid_next = 1'b1;
                    if (engaged_reg && best_valid_next)
                    begin
                        out_data_next.hit_found = 1'b1;
                        out_data_next.turn_to_hit = best_turn_next;
                        out_data_next.hit_index = best_index_next;
                    end
                    else
                    begin
                        engaged_next = 1'b0;
                        out_data_next.hit_found = 1'b0;
                        out_data_next.turn_to_hit = FULL_TURN;
                        out_data_next.hit_index = '0;
                    end
                    best_turn_next = FULL_TURN;
                    best_index_next = '0;
                    best_valid_next = 1'b0;
                    pos_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg <= '0;
            oy_reg <= '0;
            rad_reg <= '0;
            cur_reg <= '0;
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            engaged_reg <= 1'b1;
            best_valid_reg <= 1'b0;
            best_turn_reg <= FULL_TURN;
            best_index_reg <= '0;
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ORIGIN_X:      ox_reg <= cfg_data;
                    REG_ORIGIN_Y:      oy_reg <= cfg_data;
                    REG_RADIUS:        rad_reg <= cfg_data[30:0];
                    REG_CURRENT_ANGLE: cur_reg <= cfg_data;
                    default:           ;
                endcase
            end
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            engaged_reg <= engaged_next;
            best_valid_reg <= best_valid_next;
            best_turn_reg <= best_turn_next;
            best_index_reg <= best_index_next;
            pos_reg <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next; py_reg <= py_next; dx_reg <= dx_next; dy_reg <= dy_next;
        r_reg <= r_next; last_reg <= last_next;
        a_reg <= a_next; h_reg <= h_next; c_reg <= c_next; n_reg <= n_next;
        disc_reg <= disc_next; vx_reg <= vx_next; vy_reg <= vy_next;
        rem_reg <= rem_next; root_reg <= root_next;
        nx_reg <= nx_next; ny_reg <= ny_next;
        cx_reg <= cx_next; cy_reg <= cy_next; z_reg <= z_next; cskip_reg <= cskip_next;
        seg_best_reg <= seg_best_next;
        mag_a_reg <= mag_a_next; mag_b_reg <= mag_b_next; neg_reg <= neg_next;
        mode_reg <= mode_next; dst_reg <= dst_next;
        pp_reg <= pp_next; pp_sh_reg <= pp_sh_next;
        prod_reg <= prod_next; acc_reg <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign status.search_en  = engaged_reg && (pos_reg < POS_MAX);
    assign status.a_zero     = (a_reg == 64'sd0);
    assign status.disc_neg   = disc_reg[127];
    assign status.n_ok       = (n_reg > 64'sd0) && (n_reg < a_reg);
    assign status.norm_small = !(|vx_reg[127:30]) && !(|vy_reg[127:30]);
    assign status.mul_idle   = !busy_reg;
    assign status.last_item  = last_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

endmodule

// File: hw/rtl/csnhs_ctrl.sv
// ----------------------------------------------------------------------------
// csnhs_ctrl
// Sequencer that steps the datapath through one segment.
// ----------------------------------------------------------------------------
module csnhs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output csnhs_pkg::dp_cmd_t    cmd,
    input  csnhs_pkg::dp_status_t status
);
    import csnhs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_MUL,
        S_MUL_WAIT,
        S_SQRT_INIT,
        S_SQRT,
        S_CAND,
        S_CAND_CHK,
        S_NORM_LOAD,
        S_NORM,
        S_CORDIC,
        S_TURN,
        S_NEXT_CAND,
        S_FINISH
    } state_t;

    localparam logic [3:0] STEP_A_END    = 4'd1;
    localparam logic [3:0] STEP_DISC_END = 4'd8;
    localparam logic [3:0] STEP_V_START  = 4'd9;
    localparam logic [3:0] STEP_VY_END   = 4'd12;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       cand_reg, cand_next;
    logic [5:0] iter_reg, iter_next;

    // products in order: a, h, c, disc, then the hit vector
    function automatic mul_cmd_t mul_prog(input logic [3:0] s);
        mul_cmd_t m;
        case (s)
            4'd0:    m = '{SRC_DX, SRC_DX, MAC_SET, DST_NONE};
            4'd1:    m = '{SRC_DY, SRC_DY, MAC_ADD, DST_A};
            4'd2:    m = '{SRC_PX, SRC_DX, MAC_SET, DST_NONE};
            4'd3:    m = '{SRC_PY, SRC_DY, MAC_ADD, DST_H};
            4'd4:    m = '{SRC_PX, SRC_PX, MAC_SET, DST_NONE};
            4'd5:    m = '{SRC_PY, SRC_PY, MAC_ADD, DST_NONE};
            4'd6:    m = '{SRC_R,  SRC_R,  MAC_SUB, DST_C};
            4'd7:    m = '{SRC_H,  SRC_H,  MAC_SET, DST_NONE};
            4'd8:    m = '{SRC_A,  SRC_C,  MAC_SUB, DST_DISC};
            4'd9:    m = '{SRC_PX, SRC_A,  MAC_SET, DST_NONE};
            4'd10:   m = '{SRC_N,  SRC_DX, MAC_ADD, DST_VX};
            4'd11:   m = '{SRC_PY, SRC_A,  MAC_SET, DST_NONE};
            4'd12:   m = '{SRC_N,  SRC_DY, MAC_ADD, DST_VY};
            default: m = '{SRC_PX, SRC_PX, MAC_SET, DST_NONE};
        endcase
        return m;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cand_next = cand_reg;
        iter_next = iter_reg;
        cmd.op = OP_NONE;
        cmd.mul = mul_prog(step_reg);
        cmd.cand = cand_reg;
        cmd.iter = iter_reg[4:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = status.search_en ? S_SCALE : S_FINISH;
                end
            end
            S_SCALE:
            begin
                cmd.op = OP_SCALE;
                step_next = '0;
                cand_next = 1'b0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (status.mul_idle)
                begin
                    if (step_reg == STEP_A_END && status.a_zero)
                        state_next = S_FINISH;
                    else if (step_reg == STEP_DISC_END)
                        state_next = status.disc_neg ? S_FINISH : S_SQRT_INIT;
                    else if (step_reg == STEP_VY_END)
                        state_next = S_NORM_LOAD;
                    else
                    begin
                        step_next = step_reg + 4'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_SQRT_INIT:
            begin
                cmd.op = OP_SQRT_INIT;
                iter_next = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'd63)
                    state_next = S_CAND;
            end
            S_CAND:
            begin
                cmd.op = OP_CAND;
                state_next = S_CAND_CHK;
            end
            S_CAND_CHK:
            begin
                if (status.n_ok)
                begin
                    step_next = STEP_V_START;
                    state_next = S_MUL;
                end
                else
                    state_next = S_NEXT_CAND;
            end
            S_NORM_LOAD:
            begin
                cmd.op = OP_NORM_LOAD;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (status.norm_small)
                begin
                    cmd.op = OP_CORDIC_LOAD;
                    iter_next = '0;
                    state_next = S_CORDIC;
                end
                else
                    cmd.op = OP_NORM_STEP;
            end
            S_CORDIC:
            begin
                cmd.op = OP_CORDIC_STEP;
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'd31)
                    state_next = S_TURN;
            end
            S_TURN:
            begin
                cmd.op = OP_TURN;
                state_next = S_NEXT_CAND;
            end
            S_NEXT_CAND:
            begin
                if (cand_reg)
                    state_next = S_FINISH;
                else
                begin
                    cand_next = 1'b1;
                    state_next = S_CAND;
                end
            end
            S_FINISH:
            begin
                // a result needs the output register free
                if (!status.last_item || status.out_free)
                begin
                    cmd.op = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            cand_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            cand_reg <= cand_next;
            iter_reg <= iter_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// File: hw/rtl/circle_segment_next_hit_search.sv
// ----------------------------------------------------------------------------
// circle_segment_next_hit_search
// Intersects a stream of segments with a circular orbit and reports the
// nearest forward hit of each scan.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid / in_stall | seg_in_t, one segment
//  out     | from block| out_valid/out_stall | hit_out_t, one per scan
//  cfg     | to block  | cfg_wr_en           | cfg_index, cfg_data
//
// one segment at a time: a skipped segment is only loaded and finished, a searched
// one runs longer, the spread set by early exits (zero length) and by the up
// to 62 normalise shifts of each hit vector
// the time goes to the four-limb 32x32 multiply-accumulate (up to 17
// products), the 64-step square root and the 32-step cordic
// reset leaves the block engaged with an empty scan
// a stalled result holds the last segment of the next scan until taken
// ----------------------------------------------------------------------------
module circle_segment_next_hit_search #(
    parameter int MAX_SEGMENTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  csnhs_pkg::seg_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output csnhs_pkg::hit_out_t out_data
);
    import csnhs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    csnhs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    csnhs_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: hw/rtl/csnhs_checker.sv
// ----------------------------------------------------------------------------
// csnhs_checker
// Port-level checks on the next-hit search.
// ----------------------------------------------------------------------------
module csnhs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input csnhs_pkg::hit_out_t out_data
);
    import csnhs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_miss_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit_found |->
            out_data.turn_to_hit == FULL_TURN && out_data.hit_index == 10'd0)
        else $error("empty scan result malformed");

    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit_found |->
            out_data.turn_to_hit != 33'd0 &&
            (!out_data.turn_to_hit[32] || out_data.turn_to_hit[31:0] == 32'd0))
        else $error("turn outside one revolution");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !$rose(out_valid))
        else $error("segment transfer not followed by busy");

endmodule

bind circle_segment_next_hit_search csnhs_checker u_csnhs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
